/* design/prime_test_trial_division_top_macros.svh */
// Assertion macros for the trial-division prime tester.
`ifndef PRIME_TEST_TRIAL_DIVISION_TOP_MACROS_SVH
`define PRIME_TEST_TRIAL_DIVISION_TOP_MACROS_SVH

// same-cycle implication
`define PTTD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pttd_pkg.sv */
// Shared constants and command/status types for the trial-division prime tester.
`timescale 1ns / 1ps
package pttd_pkg;

    localparam int VALUE_W = 32;
    localparam int SQ_W    = VALUE_W + 1;
    localparam int CNT_W   = $clog2(VALUE_W);
    localparam int DIGITS  = VALUE_W / 2;
    // even width holding the sum of all base-4 digits
    localparam int RES3_W  = 2 * (($clog2(3 * DIGITS + 1) + 1) / 2);

    localparam logic [CNT_W-1:0]   CNT_TOP   = CNT_W'(VALUE_W - 1);
    localparam logic [VALUE_W-1:0] DIV_FIRST = VALUE_W'(5);
    localparam logic [VALUE_W-1:0] DIV_GAP   = VALUE_W'(2);
    localparam logic [VALUE_W-1:0] DIV_STEP  = VALUE_W'(6);
    localparam logic [SQ_W-1:0]    SQ_FIRST  = SQ_W'(25);  // 5*5
    localparam logic [SQ_W-1:0]    INC_FIRST = SQ_W'(96);  // 12*5 + 36
    localparam logic [SQ_W-1:0]    INC_STEP  = SQ_W'(72);  // 12*6

    // divisor selection, also the controller's phase
    localparam logic [1:0] SEL_NONE = 2'd0;
    localparam logic [1:0] SEL_D    = 2'd1;
    localparam logic [1:0] SEL_D2   = 2'd2;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic [1:0] div_sel;
        logic       div_step;
        logic       loop_init;
        logic       loop_adv;
    } cmd_t;

    typedef struct packed {
        logic neg;
        logic lt2;
        logic is2or3;
        logic even;
        logic mult3;
        logic div_last;
        logic rem_zero;
        logic sq_gt;
    } sts_t;

endpackage

/* design/pttd_datapath.sv */
// Datapath: candidate register, residue-of-three tree, bit-serial remainder and 6k+-1 stepping.
`timescale 1ns / 1ps
module pttd_datapath
(
    input  logic                        clk,
    input  logic [pttd_pkg::VALUE_W-1:0] value,
    input  pttd_pkg::cmd_t              cmd,
    output pttd_pkg::sts_t              sts
);

    logic [pttd_pkg::VALUE_W-1:0] v_reg, v_next;
    logic [pttd_pkg::VALUE_W-1:0] rem_reg, rem_next;
    logic [pttd_pkg::VALUE_W-1:0] dv_reg, dv_next;
    logic [pttd_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [pttd_pkg::VALUE_W-1:0] d_reg, d_next;
    logic [pttd_pkg::SQ_W-1:0]    sq_reg, sq_next;
    logic [pttd_pkg::SQ_W-1:0]    inc_reg, inc_next;

    logic [pttd_pkg::VALUE_W:0]   rem_shift;
    logic [pttd_pkg::VALUE_W:0]   rem_sub;
    logic [pttd_pkg::VALUE_W-1:0] dv_sel;

    // 4 is 1 mod 3, so the base-4 digit sum keeps the residue
    function automatic logic three_divides(input logic [pttd_pkg::VALUE_W-1:0] v);
        logic [pttd_pkg::RES3_W-1:0] part [pttd_pkg::DIGITS];
        logic [pttd_pkg::RES3_W-1:0] total;
        logic [3:0]                  fold;
        for (int i = 0; i < pttd_pkg::DIGITS; i++)
        begin
            part[i]      = '0;
            part[i][1:0] = v[2*i +: 2];
        end
        for (int step = 1; step < pttd_pkg::DIGITS; step = step * 2)
        begin
            for (int i = 0; i + step < pttd_pkg::DIGITS; i = i + 2 * step)
                part[i] = part[i] + part[i + step];
        end
        total = part[0];
        fold  = '0;
        for (int i = 0; i < pttd_pkg::RES3_W / 2; i++)
            fold = fold + {2'b00, total[2*i +: 2]};
        return fold inside {4'd0, 4'd3, 4'd6, 4'd9, 4'd12};
    endfunction

    always_comb
    begin
        case (cmd.div_sel)
            pttd_pkg::SEL_D:  dv_sel = d_reg;
            pttd_pkg::SEL_D2: dv_sel = d_reg + pttd_pkg::DIV_GAP;
            default:          dv_sel = d_reg;
        endcase
    end

    assign rem_shift = {rem_reg, v_reg[cnt_reg]};
    assign rem_sub   = rem_shift - {1'b0, dv_reg};

    always_comb
    begin
        v_next   = v_reg;
        rem_next = rem_reg;
        dv_next  = dv_reg;
        cnt_next = cnt_reg;
        d_next   = d_reg;
        sq_next  = sq_reg;
        inc_next = inc_reg;
        if (cmd.load)
        begin
            v_next = value;
        end
        if (cmd.div_start)
        begin
            rem_next = '0;
            dv_next  = dv_sel;
            cnt_next = pttd_pkg::CNT_TOP;
        end
        else if (cmd.div_step)
        begin
            if (rem_shift >= {1'b0, dv_reg})
                rem_next = rem_sub[pttd_pkg::VALUE_W-1:0];
            else
                rem_next = rem_shift[pttd_pkg::VALUE_W-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
        if (cmd.loop_init)
        begin
            d_next   = pttd_pkg::DIV_FIRST;
            sq_next  = pttd_pkg::SQ_FIRST;
            inc_next = pttd_pkg::INC_FIRST;
        end
        else if (cmd.loop_adv)
        begin
            d_next   = d_reg + pttd_pkg::DIV_STEP;
            sq_next  = sq_reg + inc_reg;
            inc_next = inc_reg + pttd_pkg::INC_STEP;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        rem_reg <= rem_next;
        dv_reg  <= dv_next;
        cnt_reg <= cnt_next;
        d_reg   <= d_next;
        sq_reg  <= sq_next;
        inc_reg <= inc_next;
    end

    assign sts.neg      = v_reg[pttd_pkg::VALUE_W-1];
    assign sts.lt2      = (v_reg[pttd_pkg::VALUE_W-1:1] == '0);
    assign sts.is2or3   = (v_reg[pttd_pkg::VALUE_W-1:2] == '0) && v_reg[1];
    assign sts.even     = !v_reg[0];
    assign sts.mult3    = three_divides(v_reg);
    assign sts.div_last = (cnt_reg == '0);
    assign sts.rem_zero = (rem_reg == '0);
    assign sts.sq_gt    = (sq_reg > {1'b0, v_reg});

endmodule

/* design/pttd_ctrl.sv */
// Controller: sequences the checks and divisions and holds the result register.
`timescale 1ns / 1ps
`include "prime_test_trial_division_top_macros.svh"
module pttd_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output logic           is_prime,
    output pttd_pkg::cmd_t cmd,
    input  pttd_pkg::sts_t sts
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_SQCHK = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       res_reg, res_next;
    logic       out_valid_reg, out_valid_next;
    logic       is_prime_reg, is_prime_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        is_prime_next  = is_prime_reg;
        cmd            = '0;
        cmd.div_sel    = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.neg || sts.lt2)
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else if (sts.is2or3)
                begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else if (sts.even || sts.mult3)
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.loop_init = 1'b1;
                    phase_next    = pttd_pkg::SEL_NONE;
                    state_next    = ST_SQCHK;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (sts.rem_zero)
                begin
                    res_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else if (phase_reg == pttd_pkg::SEL_D)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = pttd_pkg::SEL_D2;
                    phase_next    = pttd_pkg::SEL_D2;
                    state_next    = ST_DIV;
                end
                else
                begin
                    cmd.loop_adv = 1'b1;
                    state_next   = ST_SQCHK;
                end
            end
            ST_SQCHK:
            begin
                if (sts.sq_gt)
                begin
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = pttd_pkg::SEL_D;
                    phase_next    = pttd_pkg::SEL_D;
                    state_next    = ST_DIV;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    is_prime_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= pttd_pkg::SEL_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        is_prime_reg <= is_prime_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

    `PTTD_ASSERT_NEXT(a_div_to_eval, (state_reg == ST_DIV) && sts.div_last, state_reg == ST_EVAL, "last division step must lead to evaluation")
    `PTTD_ASSERT_NOW(a_sqchk_phase, state_reg == ST_SQCHK, phase_reg != pttd_pkg::SEL_D, "bound check reached with only one divisor of the pair tried")
    `PTTD_ASSERT_NEXT(a_check_after_load, (state_reg == ST_IDLE) && in_valid, state_reg == ST_CHECK, "accepted beat must be checked next")
    `PTTD_ASSERT_NEXT(a_beat_held, out_valid_reg && out_stall, out_valid_reg && $stable(is_prime_reg), "stalled result beat lost or changed")

endmodule

/* design/prime_test_trial_division_top.sv */
// Top level of the trial-division prime tester: controller plus datapath.
// Values below 2, 2, 3, even values and multiples of 3 are settled by the checks alone, without division.
// Else the 6k+-1 divisor pairs are tried in turn; a pair is two bit-serial remainders.
// Worst case for 32-bit values about 7700 pairs.
// One beat in flight; the next is taken once the result is in the output register.
// Reset clears the controller state, phase and output valid; the datapath, result and is_prime registers are not reset.
`timescale 1ns / 1ps
module prime_test_trial_division_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [pttd_pkg::VALUE_W-1:0] candidate,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               is_prime
);

    pttd_pkg::cmd_t cmd;
    pttd_pkg::sts_t sts;

    pttd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .is_prime  (is_prime),
        .cmd       (cmd),
        .sts       (sts)
    );

    pttd_datapath u_datapath
    (
        .clk   (clk),
        .value ($unsigned(candidate)),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule
